// ===== hdl/isle_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package isle_pkg;

   localparam int FRAME_BUFFER_BYTES_DEF = 64;

   localparam logic [7:0]  HDR_FIRST    = 8'h23;
   localparam logic [7:0]  HDR_SECOND   = 8'h3F;
   localparam logic [7:0]  CLASS_BYTE   = 8'h32;
   localparam logic [7:0]  CMD_POWER    = 8'h41;
   localparam logic [7:0]  CMD_ENERGY   = 8'h42;
   localparam logic [7:0]  CMD_LIMITS   = 8'h44;
   localparam logic [7:0]  DEV_ADDR     = 8'h01;
   localparam logic [16:0] CSUM_MAX     = 17'h0FFFF;
   localparam logic [15:0] TODAY_GATE_RESET = 16'd10;

   localparam logic [9:0] MIN_LEN_POWER  = 10'd39;
   localparam logic [9:0] MIN_LEN_ENERGY = 10'd23;
   localparam logic [9:0] MIN_LEN_LIMITS = 10'd21;
   localparam logic [9:0] LEN_OVERHEAD   = 10'd8;

   localparam logic [31:0] LINK_OFFLINE  = 32'd0;
   localparam logic [31:0] LINK_QUERYING = 32'd1;
   localparam logic [31:0] LINK_READY    = 32'd2;

   // first step of each result program
   localparam logic [4:0] PROG_TICK   = 5'd0;
   localparam logic [4:0] PROG_POWER  = 5'd2;
   localparam logic [4:0] PROG_ENERGY = 5'd14;
   localparam logic [4:0] PROG_LIMITS = 5'd18;

   typedef enum logic [1:0] {
      KIND_VALUE = 2'd0,
      KIND_TX    = 2'd1,
      KIND_LINK  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      SRC_BYTE,
      SRC_BE16,
      SRC_BE32,
      SRC_TX,
      SRC_LINK_SEEN,
      SRC_LINK_READY
   } src_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_LOAD,
      SEQ_FETCH,
      SEQ_CAPT,
      SEQ_EMIT
   } seq_state_type;

   typedef struct packed {
      src_type    src;
      kind_type   kind;
      logic [4:0] id;
      logic [1:0] scale;
      logic [5:0] addr;
      logic [7:0] cmd;
      logic       gate;
      logic       pv;
      logic       last;
   } step_type;

   typedef struct packed {
      logic       valid;
      logic [4:0] prog;
   } start_type;

   function automatic step_type mk(src_type src, kind_type kind, logic [4:0] id,
                                   logic [1:0] scale, logic [5:0] addr,
                                   logic [7:0] cmd, logic gate, logic pv,
                                   logic last);
      step_type s;
      s.src = src; s.kind = kind; s.id = id; s.scale = scale; s.addr = addr;
      s.cmd = cmd; s.gate = gate; s.pv = pv; s.last = last;
      return s;
   endfunction

   function automatic step_type step_lookup(logic [4:0] idx);
      step_type s;
      unique case (idx)
         5'd0:  s = mk(SRC_LINK_SEEN, KIND_LINK, 5'd0, 2'd0, 6'd0, 8'h00, 1'b0, 1'b0, 1'b0);
         5'd1:  s = mk(SRC_TX, KIND_TX, 5'd0, 2'd0, 6'd0, CMD_POWER, 1'b0, 1'b0, 1'b1);
         5'd2:  s = mk(SRC_BYTE, KIND_VALUE, 5'd0, 2'd0, 6'd6, 8'h00, 1'b0, 1'b0, 1'b0);
         5'd3:  s = mk(SRC_BE16, KIND_VALUE, 5'd1, 2'd1, 6'd7, 8'h00, 1'b0, 1'b0, 1'b0);
         5'd4:  s = mk(SRC_BE16, KIND_VALUE, 5'd2, 2'd1, 6'd9, 8'h00, 1'b0, 1'b0, 1'b0);
         5'd5:  s = mk(SRC_BE16, KIND_VALUE, 5'd3, 2'd1, 6'd11, 8'h00, 1'b0, 1'b1, 1'b0);
         5'd6:  s = mk(SRC_BE16, KIND_VALUE, 5'd4, 2'd1, 6'd13, 8'h00, 1'b0, 1'b0, 1'b0);
         5'd7:  s = mk(SRC_BE16, KIND_VALUE, 5'd5, 2'd1, 6'd15, 8'h00, 1'b0, 1'b0, 1'b0);
         5'd8:  s = mk(SRC_BE16, KIND_VALUE, 5'd6, 2'd2, 6'd17, 8'h00, 1'b0, 1'b0, 1'b0);
         5'd9:  s = mk(SRC_BE16, KIND_VALUE, 5'd7, 2'd1, 6'd19, 8'h00, 1'b0, 1'b0, 1'b0);
         5'd10: s = mk(SRC_BE16, KIND_VALUE, 5'd8, 2'd1, 6'd33, 8'h00, 1'b0, 1'b0, 1'b0);
         5'd11: s = mk(SRC_BE16, KIND_VALUE, 5'd9, 2'd0, 6'd35, 8'h00, 1'b0, 1'b0, 1'b0);
         5'd12: s = mk(SRC_BE16, KIND_VALUE, 5'd10, 2'd1, 6'd37, 8'h00, 1'b0, 1'b0, 1'b0);
         5'd13: s = mk(SRC_TX, KIND_TX, 5'd0, 2'd0, 6'd0, CMD_ENERGY, 1'b0, 1'b0, 1'b1);
         5'd14: s = mk(SRC_BE16, KIND_VALUE, 5'd11, 2'd1, 6'd13, 8'h00, 1'b1, 1'b0, 1'b0);
         5'd15: s = mk(SRC_BE32, KIND_VALUE, 5'd12, 2'd1, 6'd15, 8'h00, 1'b0, 1'b0, 1'b0);
         5'd16: s = mk(SRC_BE32, KIND_VALUE, 5'd13, 2'd0, 6'd19, 8'h00, 1'b0, 1'b0, 1'b0);
         5'd17: s = mk(SRC_TX, KIND_TX, 5'd0, 2'd0, 6'd0, CMD_LIMITS, 1'b0, 1'b0, 1'b1);
         5'd18: s = mk(SRC_BE16, KIND_VALUE, 5'd14, 2'd1, 6'd13, 8'h00, 1'b0, 1'b0, 1'b0);
         5'd19: s = mk(SRC_BE16, KIND_VALUE, 5'd15, 2'd1, 6'd15, 8'h00, 1'b0, 1'b0, 1'b0);
         5'd20: s = mk(SRC_BE16, KIND_VALUE, 5'd16, 2'd2, 6'd17, 8'h00, 1'b0, 1'b0, 1'b0);
         5'd21: s = mk(SRC_BE16, KIND_VALUE, 5'd17, 2'd2, 6'd19, 8'h00, 1'b0, 1'b0, 1'b0);
         default: s = mk(SRC_LINK_READY, KIND_LINK, 5'd0, 2'd0, 6'd0, 8'h00,
                         1'b0, 1'b0, 1'b1);
      endcase
      return s;
   endfunction

   // request frame byte, checksum is sum of byte xor index with saturation
   function automatic logic [7:0] tx_byte(logic [7:0] cmd, logic [2:0] idx);
      logic [7:0]  b [6];
      logic [16:0] sum;
      logic [7:0]  r;
      b[0] = HDR_SECOND; b[1] = HDR_FIRST; b[2] = DEV_ADDR; b[3] = CLASS_BYTE;
      b[4] = cmd;        b[5] = 8'h00;
      sum = '0;
      for (int i = 0; i < 6; i++) begin
         sum = sum + {9'd0, b[i] ^ 8'(i)};
         if (sum == 17'd0 || sum > CSUM_MAX) begin
            sum = CSUM_MAX;
         end
      end
      unique case (idx)
         3'd6:    r = sum[15:8];
         3'd7:    r = sum[7:0];
         default: r = b[idx];
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/isle_frame_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
module isle_frame_mem #(
   parameter int FRAME_BUFFER_BYTES = isle_pkg::FRAME_BUFFER_BYTES_DEF,
   localparam int AW = $clog2(FRAME_BUFFER_BYTES)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [7:0]    rd_data
);

   logic [7:0] mem [FRAME_BUFFER_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hdl/isle_framer.sv =====
`timescale 1ns / 1ps
`default_nettype none
module isle_framer #(
   parameter int FRAME_BUFFER_BYTES = isle_pkg::FRAME_BUFFER_BYTES_DEF,
   localparam int AW = $clog2(FRAME_BUFFER_BYTES),
   localparam int FW = $clog2(FRAME_BUFFER_BYTES + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_opcode,
   input  wire logic [7:0]            req_rx_byte,
   input  wire logic                  seq_idle,
   output logic                       mem_wr_en,
   output logic      [AW-1:0]         mem_wr_addr,
   output logic      [7:0]            mem_wr_data,
   output isle_pkg::start_type        start
);

   localparam logic [FW-1:0] FULL = FW'(FRAME_BUFFER_BYTES);

   logic [FW-1:0] fill_ff, fill_in;
   logic [7:0]    class_ff, class_in, cmd_ff, cmd_in, len_ff, len_in;
   logic          accept;
   logic [FW-1:0] fill_plus;
   logic [9:0]    total;
   logic [7:0]    len_eff;

   assign req_ready   = seq_idle;
   assign accept      = req_valid & seq_idle;
   assign mem_wr_data = req_rx_byte;
   assign fill_plus   = fill_ff + FW'(1);
   assign total       = 10'(fill_plus);
   assign len_eff     = (fill_ff == FW'(5)) ? req_rx_byte : len_ff;

   always_comb begin
      fill_in     = fill_ff;
      class_in    = class_ff;
      cmd_in      = cmd_ff;
      len_in      = len_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = fill_ff[AW-1:0];
      start       = '0;
      if (accept) begin
         if (req_opcode) begin
            fill_in     = '0;
            start.valid = 1'b1;
            start.prog  = isle_pkg::PROG_TICK;
         end else if (fill_ff >= FULL) begin
            // overflow drops the byte and the frame
            fill_in = '0;
         end else if (fill_ff == '0) begin
            if (req_rx_byte == isle_pkg::HDR_FIRST) begin
               mem_wr_en = 1'b1;
               fill_in   = FW'(1);
            end
         end else if (fill_ff == FW'(1)) begin
            if (req_rx_byte == isle_pkg::HDR_SECOND) begin
               mem_wr_en = 1'b1;
               fill_in   = FW'(2);
            end else if (req_rx_byte == isle_pkg::HDR_FIRST) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = '0;
               fill_in     = FW'(1);
            end else begin
               fill_in = '0;
            end
         end else begin
            mem_wr_en = 1'b1;
            fill_in   = fill_plus;
            if (fill_ff == FW'(3)) begin
               class_in = req_rx_byte;
            end
            if (fill_ff == FW'(4)) begin
               cmd_in = req_rx_byte;
            end
            if (fill_ff == FW'(5)) begin
               len_in = req_rx_byte;
            end
            if (fill_ff >= FW'(5) && total >= 10'(len_eff) + isle_pkg::LEN_OVERHEAD) begin
               fill_in = '0;
               if (class_ff == isle_pkg::CLASS_BYTE) begin
                  if (cmd_ff == isle_pkg::CMD_POWER && total >= isle_pkg::MIN_LEN_POWER) begin
                     start.valid = 1'b1;
                     start.prog  = isle_pkg::PROG_POWER;
                  end else if (cmd_ff == isle_pkg::CMD_ENERGY &&
                               total >= isle_pkg::MIN_LEN_ENERGY) begin
                     start.valid = 1'b1;
                     start.prog  = isle_pkg::PROG_ENERGY;
                  end else if (cmd_ff == isle_pkg::CMD_LIMITS &&
                               total >= isle_pkg::MIN_LEN_LIMITS) begin
                     start.valid = 1'b1;
                     start.prog  = isle_pkg::PROG_LIMITS;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
      class_ff <= class_in;
      cmd_ff   <= cmd_in;
      len_ff   <= len_in;
   end

endmodule
`default_nettype wire

// ===== hdl/isle_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
module isle_seq #(
   parameter int FRAME_BUFFER_BYTES = isle_pkg::FRAME_BUFFER_BYTES_DEF,
   localparam int AW = $clog2(FRAME_BUFFER_BYTES)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire isle_pkg::start_type  start,
   output logic                      seq_idle,
   output logic      [AW-1:0]        mem_rd_addr,
   input  wire logic [7:0]           mem_rd_data,
   input  wire logic                 csr_wr_en,
   input  wire logic [15:0]          csr_wr_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic      [1:0]           rsp_kind,
   output logic      [4:0]           rsp_value_id,
   output logic      [31:0]          rsp_payload,
   output logic      [1:0]           rsp_scale,
   output logic                      rsp_last
);

   isle_pkg::seq_state_type state_ff, state_in;
   logic [4:0]    idx_ff, idx_in;
   logic [2:0]    tx_idx_ff, tx_idx_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic [31:0]   acc_ff, acc_in;
   logic          seen_ff, seen_in;
   logic [15:0]   pv_ff, pv_in;
   logic [15:0]   thr_ff, thr_in;
   logic          valid_ff, valid_in;
   logic [1:0]    kind_ff, kind_in;
   logic [4:0]    id_ff, id_in;
   logic [31:0]   payload_ff, payload_in;
   logic [1:0]    scale_ff, scale_in;
   logic          last_ff, last_in;
   isle_pkg::step_type info;
   logic          out_free, tx_done;

   assign info        = isle_pkg::step_lookup(idx_ff);
   assign out_free    = !valid_ff || rsp_ready;
   assign tx_done     = (tx_idx_ff == 3'd7);
   assign seq_idle    = (state_ff == isle_pkg::SEQ_IDLE);
   assign mem_rd_addr = addr_ff;

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      tx_idx_in  = tx_idx_ff;
      addr_in    = addr_ff;
      cnt_in     = cnt_ff;
      acc_in     = acc_ff;
      seen_in    = seen_ff;
      pv_in      = pv_ff;
      thr_in     = csr_wr_en ? csr_wr_data : thr_ff;
      valid_in   = valid_ff && !rsp_ready;
      kind_in    = kind_ff;
      id_in      = id_ff;
      payload_in = payload_ff;
      scale_in   = scale_ff;
      last_in    = last_ff;
      unique case (state_ff)
         isle_pkg::SEQ_IDLE: begin
            if (start.valid) begin
               idx_in    = start.prog;
               tx_idx_in = '0;
               if (start.prog == isle_pkg::PROG_POWER) begin
                  seen_in = 1'b1;
               end
               state_in = isle_pkg::SEQ_LOAD;
            end
         end
         isle_pkg::SEQ_LOAD: begin
            if (info.gate && !(pv_ff > thr_ff)) begin
               // today energy withheld while pv power is low
               idx_in = idx_ff + 5'd1;
            end else if (info.src == isle_pkg::SRC_BYTE ||
                         info.src == isle_pkg::SRC_BE16 ||
                         info.src == isle_pkg::SRC_BE32) begin
               addr_in  = AW'(info.addr);
               acc_in   = '0;
               cnt_in   = (info.src == isle_pkg::SRC_BE32) ? 2'd3 :
                          (info.src == isle_pkg::SRC_BE16) ? 2'd1 : 2'd0;
               state_in = isle_pkg::SEQ_FETCH;
            end else begin
               state_in = isle_pkg::SEQ_EMIT;
            end
         end
         isle_pkg::SEQ_FETCH: begin
            state_in = isle_pkg::SEQ_CAPT;
         end
         isle_pkg::SEQ_CAPT: begin
            acc_in = {acc_ff[23:0], mem_rd_data};
            if (cnt_ff == 2'd0) begin
               state_in = isle_pkg::SEQ_EMIT;
            end else begin
               cnt_in   = cnt_ff - 2'd1;
               addr_in  = addr_ff + AW'(1);
               state_in = isle_pkg::SEQ_FETCH;
            end
         end
         isle_pkg::SEQ_EMIT: begin
            if (out_free) begin
               valid_in = 1'b1;
               kind_in  = info.kind;
               id_in    = info.id;
               scale_in = info.scale;
               last_in  = info.last && (info.src != isle_pkg::SRC_TX || tx_done);
               unique case (info.src)
                  isle_pkg::SRC_TX:
                     payload_in = {24'd0, isle_pkg::tx_byte(info.cmd, tx_idx_ff)};
                  isle_pkg::SRC_LINK_SEEN: begin
                     payload_in = seen_ff ? isle_pkg::LINK_QUERYING
                                          : isle_pkg::LINK_OFFLINE;
                     seen_in    = 1'b0;
                  end
                  isle_pkg::SRC_LINK_READY:
                     payload_in = isle_pkg::LINK_READY;
                  default:
                     payload_in = acc_ff;
               endcase
               if (info.pv) begin
                  pv_in = acc_ff[15:0];
               end
               if (info.src == isle_pkg::SRC_TX && !tx_done) begin
                  tx_idx_in = tx_idx_ff + 3'd1;
               end else begin
                  tx_idx_in = '0;
                  if (info.last) begin
                     state_in = isle_pkg::SEQ_IDLE;
                  end else begin
                     idx_in   = idx_ff + 5'd1;
                     state_in = isle_pkg::SEQ_LOAD;
                  end
               end
            end
         end
         default: state_in = isle_pkg::SEQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= isle_pkg::SEQ_IDLE;
         idx_ff    <= '0;
         tx_idx_ff <= '0;
         seen_ff   <= 1'b0;
         pv_ff     <= '0;
         thr_ff    <= isle_pkg::TODAY_GATE_RESET;
         valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         idx_ff    <= idx_in;
         tx_idx_ff <= tx_idx_in;
         seen_ff   <= seen_in;
         pv_ff     <= pv_in;
         thr_ff    <= thr_in;
         valid_ff  <= valid_in;
      end
      addr_ff    <= addr_in;
      cnt_ff     <= cnt_in;
      acc_ff     <= acc_in;
      kind_ff    <= kind_in;
      id_ff      <= id_in;
      payload_ff <= payload_in;
      scale_ff   <= scale_in;
      last_ff    <= last_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_kind     = kind_ff;
   assign rsp_value_id = id_ff;
   assign rsp_payload  = payload_ff;
   assign rsp_scale    = scale_ff;
   assign rsp_last     = last_ff;

endmodule
`default_nettype wire

// ===== hdl/inverter_serial_link_engine.sv =====
// flow: a byte is taken while the sequencer is idle; a tick emits link status, then the
// request bytes; a completed frame starts its program, which reads each value from the
// buffer byte by byte (fetch, then capture) and emits it; emits wait while results stall
// throughput: bytes that cause no result back to back; a power reply holds off input
// while its 19 results go out, set by the single buffer read port
// reset: clears framing, sequencer, link flags and the gate threshold (to 10); no buffer clear
`timescale 1ns / 1ps
`default_nettype none
module inverter_serial_link_engine #(
   parameter int FRAME_BUFFER_BYTES = isle_pkg::FRAME_BUFFER_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_opcode,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [1:0]  rsp_kind,
   output logic      [4:0]  rsp_value_id,
   output logic      [31:0] rsp_payload,
   output logic      [1:0]  rsp_scale,
   output logic             rsp_last,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   localparam int AW = $clog2(FRAME_BUFFER_BYTES);

   logic                mem_wr_en;
   logic [AW-1:0]       mem_wr_addr, mem_rd_addr;
   logic [7:0]          mem_wr_data, mem_rd_data;
   logic                seq_idle;
   isle_pkg::start_type start;

   isle_frame_mem #(.FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   isle_framer #(.FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)) u_framer (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_opcode  (req_opcode),
      .req_rx_byte (req_rx_byte),
      .seq_idle    (seq_idle),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .start       (start)
   );

   isle_seq #(.FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)) u_seq (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .seq_idle     (seq_idle),
      .mem_rd_addr  (mem_rd_addr),
      .mem_rd_data  (mem_rd_data),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_kind     (rsp_kind),
      .rsp_value_id (rsp_value_id),
      .rsp_payload  (rsp_payload),
      .rsp_scale    (rsp_scale),
      .rsp_last     (rsp_last)
   );

endmodule
`default_nettype wire

// ===== hdl/isle_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module isle_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_kind,
   input wire logic [4:0]  rsp_value_id,
   input wire logic [31:0] rsp_payload,
   input wire logic [1:0]  rsp_scale
);

   localparam logic [1:0] KIND_BAD  = 2'd3;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result item dropped or changed while stalled");

   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kind != KIND_BAD && rsp_scale != 2'd3 && rsp_value_id <= 5'd17)
      else $error("illegal result kind, scale or id");

   a_tx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == isle_pkg::KIND_TX |->
         rsp_value_id == 5'd0 && rsp_scale == 2'd0 && rsp_payload[31:8] == 24'd0)
      else $error("transmit item with stray fields");

   a_link: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == isle_pkg::KIND_LINK |->
         rsp_payload <= 32'd2 && rsp_value_id == 5'd0)
      else $error("bad link status code");

endmodule

bind inverter_serial_link_engine isle_checker u_isle_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_kind     (rsp_kind),
   .rsp_value_id (rsp_value_id),
   .rsp_payload  (rsp_payload),
   .rsp_scale    (rsp_scale)
);
`default_nettype wire

// ===== bench/tb_inverter_serial_link_engine.sv =====
`timescale 1ns / 1ps
module tb_inverter_serial_link_engine;

   typedef struct {
      logic       opcode;
      logic [7:0] rx_byte;
   } link_item_type;

   typedef struct {
      logic [1:0]  kind;
      logic [4:0]  value_id;
      logic [31:0] payload;
      logic [1:0]  scale;
      logic        last;
   } link_result_type;

   localparam int STORE_BYTES = isle_pkg::FRAME_BUFFER_BYTES_DEF;
   localparam int CYCLE_LIMIT = 600000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_opcode = 1'b0;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [4:0]  rsp_value_id;
   logic [31:0] rsp_payload;
   logic [1:0]  rsp_scale;
   logic        rsp_last;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'h0000;

   link_item_type   pending_items[$];
   link_result_type expected_results[$];

   // predictor state
   logic [7:0]  frame_bytes [STORE_BYTES];
   int unsigned frame_fill = 0;
   logic        power_seen = 1'b0;
   logic [15:0] pv_watt_raw = '0;
   logic [15:0] gate_thr = isle_pkg::TODAY_GATE_RESET;

   int accepted_items = 0;
   int mismatches = 0;
   int cycles = 0;
   int stall_left = 0;
   bit long_stall_done = 0;

   inverter_serial_link_engine u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_opcode(req_opcode), .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind), .rsp_value_id(rsp_value_id), .rsp_payload(rsp_payload),
      .rsp_scale(rsp_scale), .rsp_last(rsp_last),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic void add_result(isle_pkg::kind_type k, logic [4:0] id, logic [31:0] p,
                                      logic [1:0] sc);
      link_result_type r;
      r.kind = k; r.value_id = id; r.payload = p; r.scale = sc; r.last = 1'b0;
      expected_results.push_back(r);
   endfunction

   function automatic logic [31:0] word16(int i);
      return {16'h0, frame_bytes[i], frame_bytes[i+1]};
   endfunction

   function automatic logic [31:0] word32(int i);
      return {frame_bytes[i], frame_bytes[i+1], frame_bytes[i+2], frame_bytes[i+3]};
   endfunction

   function automatic void add_request(logic [7:0] cmd);
      logic [7:0]  tx [8];
      logic [31:0] sum;
      sum = 0;
      tx[0] = isle_pkg::HDR_SECOND; tx[1] = isle_pkg::HDR_FIRST;
      tx[2] = isle_pkg::DEV_ADDR;   tx[3] = isle_pkg::CLASS_BYTE;
      tx[4] = cmd;                  tx[5] = 8'h00;
      for (int i = 0; i < 6; i++) begin
         sum = sum + (tx[i] ^ 8'(i));
         if (sum == 0 || sum > 32'hFFFF) sum = 32'hFFFF;
      end
      tx[6] = sum[15:8];
      tx[7] = sum[7:0];
      for (int i = 0; i < 8; i++) add_result(isle_pkg::KIND_TX, 5'd0, {24'h0, tx[i]}, 2'd0);
   endfunction

   function automatic void decode_reply();
      logic [7:0] cmd;
      cmd = frame_bytes[4];
      if (frame_bytes[3] != isle_pkg::CLASS_BYTE) return;
      if (cmd == isle_pkg::CMD_POWER && frame_fill >= 39) begin
         add_result(isle_pkg::KIND_VALUE, 5'd0, {24'h0, frame_bytes[6]}, 2'd0);
         add_result(isle_pkg::KIND_VALUE, 5'd1, word16(7), 2'd1);
         add_result(isle_pkg::KIND_VALUE, 5'd2, word16(9), 2'd1);
         add_result(isle_pkg::KIND_VALUE, 5'd3, word16(11), 2'd1);
         pv_watt_raw = 16'(word16(11));
         add_result(isle_pkg::KIND_VALUE, 5'd4, word16(13), 2'd1);
         add_result(isle_pkg::KIND_VALUE, 5'd5, word16(15), 2'd1);
         add_result(isle_pkg::KIND_VALUE, 5'd6, word16(17), 2'd2);
         add_result(isle_pkg::KIND_VALUE, 5'd7, word16(19), 2'd1);
         add_result(isle_pkg::KIND_VALUE, 5'd8, word16(33), 2'd1);
         add_result(isle_pkg::KIND_VALUE, 5'd9, word16(35), 2'd0);
         add_result(isle_pkg::KIND_VALUE, 5'd10, word16(37), 2'd1);
         power_seen = 1'b1;
         add_request(isle_pkg::CMD_ENERGY);
      end else if (cmd == isle_pkg::CMD_ENERGY && frame_fill >= 23) begin
         if (pv_watt_raw > gate_thr)
            add_result(isle_pkg::KIND_VALUE, 5'd11, word16(13), 2'd1);
         add_result(isle_pkg::KIND_VALUE, 5'd12, word32(15), 2'd1);
         add_result(isle_pkg::KIND_VALUE, 5'd13, word32(19), 2'd0);
         add_request(isle_pkg::CMD_LIMITS);
      end else if (cmd == isle_pkg::CMD_LIMITS && frame_fill >= 21) begin
         add_result(isle_pkg::KIND_VALUE, 5'd14, word16(13), 2'd1);
         add_result(isle_pkg::KIND_VALUE, 5'd15, word16(15), 2'd1);
         add_result(isle_pkg::KIND_VALUE, 5'd16, word16(17), 2'd2);
         add_result(isle_pkg::KIND_VALUE, 5'd17, word16(19), 2'd2);
         add_result(isle_pkg::KIND_LINK, 5'd0, isle_pkg::LINK_READY, 2'd0);
      end
   endfunction

   function automatic void predict_link(logic opcode, logic [7:0] b);
      int first;
      first = expected_results.size();
      if (opcode) begin
         frame_fill = 0;
         add_result(isle_pkg::KIND_LINK, 5'd0,
                    power_seen ? isle_pkg::LINK_QUERYING : isle_pkg::LINK_OFFLINE, 2'd0);
         power_seen = 1'b0;
         add_request(isle_pkg::CMD_POWER);
      end else if (frame_fill >= STORE_BYTES) begin
         frame_fill = 0;
      end else if (frame_fill == 0) begin
         if (b == isle_pkg::HDR_FIRST) begin
            frame_bytes[0] = b; frame_fill = 1;
         end
      end else if (frame_fill == 1) begin
         if (b == isle_pkg::HDR_SECOND) begin
            frame_bytes[1] = b; frame_fill = 2;
         end else if (b == isle_pkg::HDR_FIRST) begin
            frame_bytes[0] = b; frame_fill = 1;
         end else begin
            frame_fill = 0;
         end
      end else begin
         frame_bytes[frame_fill] = b;
         frame_fill++;
         if (frame_fill > 5 && frame_fill >= frame_bytes[5] + 8) begin
            decode_reply();
            frame_fill = 0;
         end
      end
      if (expected_results.size() > first)
         expected_results[expected_results.size()-1].last = 1'b1;
   endfunction

   function automatic void push_item(logic opcode, logic [7:0] b);
      link_item_type it;
      it.opcode = opcode; it.rx_byte = b;
      pending_items.push_back(it);
   endfunction

   // header, address, class, command, length field, then data up to total bytes
   function automatic void push_frame(logic [7:0] cls, logic [7:0] cmd, logic [7:0] len_field,
                                      int total, int fill_mode);
      logic [7:0] b;
      for (int i = 0; i < total; i++) begin
         case (i)
            0: b = isle_pkg::HDR_FIRST;
            1: b = isle_pkg::HDR_SECOND;
            2: b = isle_pkg::DEV_ADDR;
            3: b = cls;
            4: b = cmd;
            5: b = len_field;
            default: begin
               if (fill_mode == 1) b = 8'hFF;
               else if (fill_mode == 2) b = 8'h00;
               else b = 8'($urandom);
               // low pv watts now and then so the today gate goes both ways
               if (i == 11 && fill_mode == 0 && $urandom_range(0, 1)) b = 8'h00;
               if (i == 12 && fill_mode == 0 && $urandom_range(0, 1))
                  b = 8'($urandom_range(0, 20));
            end
         endcase
         push_item(1'b0, b);
      end
   endfunction

   function automatic void push_reply(logic [7:0] cmd, int fill_mode);
      int len;
      len = (cmd == isle_pkg::CMD_POWER) ? 31 : (cmd == isle_pkg::CMD_ENERGY) ? 15 : 13;
      push_frame(isle_pkg::CLASS_BYTE, cmd, 8'(len), len + 8, fill_mode);
   endfunction

   function automatic bit idle_now();
      if (accepted_items > 200 && accepted_items < 320) return 0;
      return $urandom_range(0, 99) < 6;
   endfunction

   // sender
   always @(posedge clock) begin
      link_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_link(req_opcode, req_rx_byte);
            accepted_items++;
         end
         if (!req_valid || req_ready) begin
            if (pending_items.size() != 0 && !idle_now()) begin
               it = pending_items.pop_front();
               req_valid <= 1'b1;
               req_opcode <= it.opcode;
               req_rx_byte <= it.rx_byte;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver, with one long hold-off while the sender keeps going
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!long_stall_done && accepted_items >= 150) begin
         long_stall_done = 1;
         stall_left = 1500;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !idle_now();
      end
   end

   // result check
   always @(posedge clock) begin
      link_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result kind=%0d id=%0d payload=%h", rsp_kind,
                        rsp_value_id, rsp_payload);
         end else begin
            want = expected_results.pop_front();
            if (rsp_kind !== want.kind || rsp_value_id !== want.value_id ||
                rsp_payload !== want.payload || rsp_scale !== want.scale ||
                rsp_last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: exp kind=%0d id=%0d payload=%h scale=%0d last=%0d,",
                            " got kind=%0d id=%0d payload=%h scale=%0d last=%0d"},
                           want.kind, want.value_id, want.payload, want.scale, want.last,
                           rsp_kind, rsp_value_id, rsp_payload, rsp_scale, rsp_last);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_inverter_serial_link_engine failed");
         $finish;
      end
   end

   task automatic drain();
      while (pending_items.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_gate(logic [15:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      gate_thr = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_phase(int count);
      int start;
      int pick;
      int len;
      start = pending_items.size() + accepted_items;
      while (pending_items.size() + accepted_items - start < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) push_reply(isle_pkg::CMD_POWER, 0);
         else if (pick < 45) push_reply(isle_pkg::CMD_ENERGY, 0);
         else if (pick < 60) push_reply(isle_pkg::CMD_LIMITS, 0);
         else if (pick < 68) push_item(1'b1, 8'($urandom));
         else if (pick < 75) begin
            // short or oversized length field
            len = $urandom_range(0, 1) ? $urandom_range(0, 30) : $urandom_range(56, 255);
            push_frame(isle_pkg::CLASS_BYTE,
                       $urandom_range(0, 1) ? isle_pkg::CMD_POWER : isle_pkg::CMD_ENERGY,
                       8'(len), (len + 8 > 70) ? 70 : len + 8, 0);
         end else if (pick < 80) begin
            len = $urandom_range(13, 31);
            push_frame(8'($urandom), 8'($urandom), 8'(len), len + 8, 0);
         end else if (pick < 88) begin
            // truncated frame
            push_frame(isle_pkg::CLASS_BYTE, isle_pkg::CMD_POWER, 8'd31,
                       $urandom_range(1, 30), 0);
         end else begin
            repeat ($urandom_range(1, 5)) push_item(1'b0, 8'($urandom));
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed
      push_item(1'b1, 8'h00);
      push_reply(isle_pkg::CMD_POWER, 1);
      push_item(1'b1, 8'hFF);
      push_item(1'b1, 8'h00);
      push_reply(isle_pkg::CMD_ENERGY, 2);
      push_reply(isle_pkg::CMD_LIMITS, 1);
      push_frame(isle_pkg::CLASS_BYTE, isle_pkg::CMD_POWER, 8'd30, 38, 1);
      push_frame(isle_pkg::CLASS_BYTE, isle_pkg::CMD_ENERGY, 8'd14, 22, 1);
      push_frame(isle_pkg::CLASS_BYTE, isle_pkg::CMD_LIMITS, 8'd12, 20, 1);
      push_frame(8'h31, isle_pkg::CMD_LIMITS, 8'd13, 21, 1);
      push_frame(isle_pkg::CLASS_BYTE, 8'h43, 8'd0, 8, 1);
      push_item(1'b0, isle_pkg::HDR_FIRST);
      push_item(1'b0, 8'h00);
      push_item(1'b0, isle_pkg::HDR_FIRST);
      push_item(1'b0, isle_pkg::HDR_FIRST);
      push_frame(isle_pkg::CLASS_BYTE, isle_pkg::CMD_POWER, 8'd255, 65, 1);
      push_item(1'b1, 8'h5A);
      drain();

      write_gate(16'h0000);
      push_reply(isle_pkg::CMD_POWER, 0);
      push_reply(isle_pkg::CMD_ENERGY, 0);
      drain();

      write_gate(16'hFFFF);
      push_reply(isle_pkg::CMD_ENERGY, 1);
      drain();

      write_gate(16'($urandom));
      random_phase(20);
      drain();

      write_gate(isle_pkg::TODAY_GATE_RESET);

      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("tb_inverter_serial_link_engine passed");
      end else begin
         $display("tb_inverter_serial_link_engine failed");
      end
      $finish;
   end

endmodule
